>>> hw/rtl/ip_address_scope_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IP address scope classifier
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_SCOPE_CLASSIFIER_MACROS_SVH
`define IP_ADDRESS_SCOPE_CLASSIFIER_MACROS_SVH

// Plain property, checked at every edge outside reset.
`define IPASC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ipasc assertion failed");

// Implication in the same cycle.
`define IPASC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipasc assertion failed");

// Implication into the next cycle.
`define IPASC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipasc assertion failed");

`endif

>>> hw/rtl/ipasc_pkg.sv
// ----------------------------------------------------------------------------
// ipasc_pkg
// Widths, family codes, scope codes and IPv4 sub-range constants.
// ----------------------------------------------------------------------------
package ipasc_pkg;

  localparam int FamilyW = 2;
  localparam int AddrW   = 64;
  localparam int ScopeW  = 3;

  localparam logic [FamilyW-1:0] FAM_OTHER = 2'd0;
  localparam logic [FamilyW-1:0] FAM_V4    = 2'd1;
  localparam logic [FamilyW-1:0] FAM_V6    = 2'd2;

  typedef enum logic [ScopeW-1:0] {
    SC_NONE    = 3'd0,
    SC_MCAST   = 3'd1,
    SC_LOOP    = 3'd2,
    SC_PSEUDO  = 3'd3,
    SC_GLOBAL  = 3'd4,
    SC_LINKLOC = 3'd5,
    SC_SHARED  = 3'd6,
    SC_PRIVATE = 3'd7
  } scope_t;

  // IPv4 sub-range tests
  localparam logic [31:0] V4_MASK10    = 32'hffc0_0000;
  localparam logic [31:0] V4_SHARED    = 32'h6440_0000;
  localparam logic [31:0] V4_MASK16    = 32'hffff_0000;
  localparam logic [31:0] V4_LINKLOC   = 32'ha9fe_0000;
  localparam logic [31:0] V4_MASK12    = 32'hfff0_0000;
  localparam logic [31:0] V4_PRIV172   = 32'hac10_0000;
  localparam logic [31:0] V4_PRIV192   = 32'hc0a8_0000;

  // IPv4 top nibbles
  localparam logic [3:0] V4_NIB_MCAST = 4'he;
  localparam logic [3:0] V4_NIB_RSVD  = 4'hf;

  // IPv6 prefix bytes
  localparam logic [7:0] V6_MCAST_B0   = 8'hff;
  localparam logic [7:0] V6_LINKLOC_B0 = 8'hfe;
  localparam logic [1:0] V6_LINKLOC_B1 = 2'b10;
  localparam logic [6:0] V6_ULA_B0     = 7'b1111110;

endpackage

>>> hw/rtl/ipasc_in_if.sv
// ----------------------------------------------------------------------------
// ipasc_in_if
// Address channel: valid/ready handshake carrying family and 128-bit address.
// ----------------------------------------------------------------------------
interface ipasc_in_if
  import ipasc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FamilyW-1:0] family;
  logic [AddrW-1:0]   addr_high;
  logic [AddrW-1:0]   addr_low;

  modport source (output valid, output family, output addr_high, output addr_low,
                  input ready);
  modport sink   (input valid, input family, input addr_high, input addr_low,
                  output ready);
endinterface

>>> hw/rtl/ipasc_out_if.sv
// ----------------------------------------------------------------------------
// ipasc_out_if
// Result channel: valid/ready handshake carrying the scope code.
// ----------------------------------------------------------------------------
interface ipasc_out_if
  import ipasc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ScopeW-1:0] scope;

  modport source (output valid, output scope, input ready);
  modport sink   (input valid, input scope, output ready);
endinterface

>>> hw/rtl/ipasc_classify.sv
// ----------------------------------------------------------------------------
// ipasc_classify
// Combinational scope decode of one IPv4 or IPv6 address.
// ----------------------------------------------------------------------------
module ipasc_classify
  import ipasc_pkg::*;
(
  input  logic [FamilyW-1:0] family,
  input  logic [AddrW-1:0]   addr_high,
  input  logic [AddrW-1:0]   addr_low,
  output scope_t             scope
);

  logic [31:0] a4;
  logic [7:0]  octet;
  logic        v4_hit;
  scope_t      v4_scope;

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b15;
  logic        mid_zero;
  scope_t      v6_scope;

  assign a4    = addr_low[31:0];
  assign octet = a4[31:24];

  always_comb begin
    v4_hit   = 1'b1;
    v4_scope = SC_GLOBAL;
    case (octet)
      8'h00, 8'hff: v4_scope = SC_NONE;
      8'h06, 8'h0b, 8'h15, 8'h16, 8'h19, 8'h1a, 8'h1c,
      8'h1d, 8'h1e, 8'h2c, 8'h33, 8'h37, 8'h38: v4_scope = SC_PSEUDO;
      8'h0a: v4_scope = SC_PRIVATE;
      8'h7f: v4_scope = SC_LOOP;
      8'h64: begin
        if ((a4 & V4_MASK10) == V4_SHARED) v4_scope = SC_SHARED;
        else v4_hit = 1'b0;
      end
      8'ha9: begin
        if ((a4 & V4_MASK16) == V4_LINKLOC) v4_scope = SC_LINKLOC;
        else v4_hit = 1'b0;
      end
      8'hac: begin
        if ((a4 & V4_MASK12) == V4_PRIV172) v4_scope = SC_PRIVATE;
        else v4_hit = 1'b0;
      end
      8'hc0: begin
        if ((a4 & V4_MASK16) == V4_PRIV192) v4_scope = SC_PRIVATE;
        else v4_hit = 1'b0;
      end
      default: v4_hit = 1'b0;
    endcase
    // fall back to the /4 split when the table gives no answer
    if (!v4_hit) begin
      case (a4[31:28])
        V4_NIB_MCAST: v4_scope = SC_MCAST;
        V4_NIB_RSVD:  v4_scope = SC_PSEUDO;
        default:      v4_scope = SC_GLOBAL;
      endcase
    end
  end

  assign b0       = addr_high[63:56];
  assign b1       = addr_high[55:48];
  assign b15      = addr_low[7:0];
  assign mid_zero = (addr_high[47:0] == '0) && (addr_low[63:8] == '0);

  always_comb begin
    v6_scope = SC_GLOBAL;
    if (b0 == V6_MCAST_B0) begin
      v6_scope = SC_MCAST;
    end else if (b0 == V6_LINKLOC_B0 && b1[7:6] == V6_LINKLOC_B1) begin
      v6_scope = (mid_zero && b15 == 8'h01) ? SC_LOOP : SC_LINKLOC;
    end else if (b0[7:1] == V6_ULA_B0) begin
      v6_scope = SC_PRIVATE;
    end else if (b0 == 8'h00 && b1 == 8'h00 && mid_zero) begin
      if (b15 == 8'h01) v6_scope = SC_LOOP;
      else if (b15 == 8'h00) v6_scope = SC_NONE;
    end
  end

  always_comb begin
    case (family)
      FAM_V4:  scope = v4_scope;
      FAM_V6:  scope = v6_scope;
      default: scope = SC_NONE;
    endcase
  end

endmodule

>>> hw/rtl/ip_address_scope_classifier.sv
// ----------------------------------------------------------------------------
// ip_address_scope_classifier
// Classifies one IP address per transfer into a 3-bit scope code.
// ----------------------------------------------------------------------------
// Usage:
//   addr_in  : sink of address transfers (family, addr_high, addr_low).
//              IPv4 sits in addr_low[31:0]; IPv6 spans addr_high:addr_low.
//   scope_out: source of result transfers, one scope code per address.
// Path: each address is held in the input register, then its decoded scope
//   is held in the result register, which drives scope_out; a stall on
//   scope_out.ready can hold an item in either register.
// Throughput: one address per cycle while scope_out.ready is high; a single
//   pass of table lookup and prefix compares lies between the two registers.
// Reset: rst (synchronous) empties both registers; addr_in.ready is high
//   again in the first cycle after reset.
// Stall: while scope_out.ready is low the result holds; the input register
//   still takes one more address, and addr_in.ready drops once both are full.
//   Ready propagates back combinationally through the two stages.
// ----------------------------------------------------------------------------
`include "ip_address_scope_classifier_macros.svh"

module ip_address_scope_classifier
  import ipasc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ipasc_in_if.sink           addr_in,
  ipasc_out_if.source        scope_out
);

  // input register
  logic               s1_valid;
  logic [FamilyW-1:0] s1_family;
  logic [AddrW-1:0]   s1_addr_high;
  logic [AddrW-1:0]   s1_addr_low;

  // result register
  logic               out_valid;
  scope_t             scope_q;

  scope_t             scope_comb;
  logic               out_free;
  logic               s1_adv;
  logic               in_take;

  assign out_free = !out_valid || scope_out.ready;
  assign s1_adv   = s1_valid && out_free;
  assign addr_in.ready = !s1_valid || out_free;
  assign in_take  = addr_in.valid && addr_in.ready;

  ipasc_classify u_classify (
    .family    (s1_family),
    .addr_high (s1_addr_high),
    .addr_low  (s1_addr_low),
    .scope     (scope_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (addr_in.ready) begin
      s1_valid <= addr_in.valid;
    end
    if (in_take) begin
      s1_family    <= addr_in.family;
      s1_addr_high <= addr_in.addr_high;
      s1_addr_low  <= addr_in.addr_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (s1_adv) begin
      scope_q <= scope_comb;
    end
  end

  assign scope_out.valid = out_valid;
  assign scope_out.scope = scope_q;

  // both stages full and stalled: no new address may enter
  `IPASC_ASSERT_IMPL(a_full_blocks, s1_valid && out_valid && !scope_out.ready, !addr_in.ready)
  // an advancing item lands in the result register with its decoded scope
  `IPASC_ASSERT_NEXT(a_adv_lands, s1_adv, out_valid && scope_q == $past(scope_comb))
  // a drained result with nothing behind it leaves the output empty
  `IPASC_ASSERT_NEXT(a_drain, out_valid && scope_out.ready && !s1_valid, !out_valid)
  // an unknown family never reaches the IPv4 or IPv6 decode
  `IPASC_ASSERT_IMPL(a_unknown_none, s1_valid && s1_family != FAM_V4 && s1_family != FAM_V6, scope_comb == SC_NONE)

endmodule

>>> dv/ip_address_scope_classifier_tb.sv
// ----------------------------------------------------------------------------
// ip_address_scope_classifier_tb
// Drives IPv4, IPv6 and unknown-family addresses through the classifier under
// random source gaps and sink stalls, and checks every scope code against a
// behavioral scope decoder kept in this bench.
// ----------------------------------------------------------------------------
module ip_address_scope_classifier_tb
  import ipasc_pkg::*;
();

  localparam logic [FamilyW-1:0] FAM_RSVD = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // First octets that the IPv4 table decides outright
  localparam logic [7:0] V4_TABLE_OCTETS [17] = '{
    8'h00, 8'h06, 8'h0b, 8'h15, 8'h16, 8'h19, 8'h1a, 8'h1c, 8'h1d,
    8'h1e, 8'h2c, 8'h33, 8'h37, 8'h38, 8'h0a, 8'h7f, 8'hff
  };

  logic clk;
  logic rst;

  ipasc_in_if  addr_ch ();
  ipasc_out_if scope_ch ();

  ip_address_scope_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .addr_in   (addr_ch),
    .scope_out (scope_ch)
  );

  scope_t expected_scopes [$];
  int     mismatch_count = 0;
  int     tx_idle_pct    = 0;
  int     rx_idle_pct    = 0;
  int     stall_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic scope_t decode_v4(input logic [31:0] a);
    case (a[31:24])
      8'h00: return SC_NONE;
      8'h06, 8'h0b, 8'h15, 8'h16, 8'h19, 8'h1a, 8'h1c, 8'h1d, 8'h1e,
      8'h2c, 8'h33, 8'h37, 8'h38: return SC_PSEUDO;
      8'h0a: return SC_PRIVATE;
      8'h64: if ((a & V4_MASK10) == V4_SHARED) return SC_SHARED;
      8'h7f: return SC_LOOP;
      8'ha9: if ((a & V4_MASK16) == V4_LINKLOC) return SC_LINKLOC;
      8'hac: if ((a & V4_MASK12) == V4_PRIV172) return SC_PRIVATE;
      8'hc0: if ((a & V4_MASK16) == V4_PRIV192) return SC_PRIVATE;
      8'hff: return SC_NONE;
      default: ;
    endcase
    // sub-range misses and unlisted octets fall through to the nibble test
    if (a[31:28] == V4_NIB_MCAST) return SC_MCAST;
    if (a[31:28] == V4_NIB_RSVD) return SC_PSEUDO;
    return SC_GLOBAL;
  endfunction

  function automatic scope_t decode_v6(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b15;
    logic       mid_zero;
    b0       = hi[63:56];
    b1       = hi[55:48];
    b15      = lo[7:0];
    mid_zero = (hi[47:0] == '0) && (lo[63:8] == '0);
    if (b0[7:4] == 4'hf) begin
      if (b0 == V6_MCAST_B0) return SC_MCAST;
      if (b0 == V6_LINKLOC_B0 && b1[7:6] == V6_LINKLOC_B1) begin
        if (mid_zero && b15 == 8'h01) return SC_LOOP;
        return SC_LINKLOC;
      end
      if (b0[7:1] == V6_ULA_B0) return SC_PRIVATE;
    end
    if (hi == '0 && lo[63:8] == '0) begin
      if (b15 == 8'h01) return SC_LOOP;
      if (b15 == 8'h00) return SC_NONE;
    end
    return SC_GLOBAL;
  endfunction

  function automatic scope_t decode_scope(input logic [FamilyW-1:0] fam,
                                          input logic [63:0] hi, input logic [63:0] lo);
    if (fam == FAM_V4) return decode_v4(lo[31:0]);
    if (fam == FAM_V6) return decode_v6(hi, lo);
    return SC_NONE;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Result check, expectation capture and watchdog
  always @(posedge clk) begin
    scope_t want;
    if (!rst) begin
      if (scope_ch.valid && scope_ch.ready) begin
        if (expected_scopes.size() == 0) begin
          note_mismatch($sformatf("unexpected scope %0d", scope_ch.scope));
        end else begin
          want = expected_scopes.pop_front();
          if (scope_ch.scope !== want)
            note_mismatch($sformatf("scope expected %0d (%s) got %0d",
                                    want, want.name(), scope_ch.scope));
        end
      end
      if (addr_ch.valid && addr_ch.ready)
        expected_scopes.push_back(decode_scope(addr_ch.family, addr_ch.addr_high,
                                               addr_ch.addr_low));
      if ((scope_ch.valid && scope_ch.ready) || (addr_ch.valid && addr_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result sink with random stalls
  always @(posedge clk) begin
    scope_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_address(input logic [FamilyW-1:0] fam,
                              input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < tx_idle_pct) begin
      addr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    addr_ch.valid     <= 1'b1;
    addr_ch.family    <= fam;
    addr_ch.addr_high <= hi;
    addr_ch.addr_low  <= lo;
    // hold until the transfer
    do @(posedge clk); while (!addr_ch.ready);
  endtask

  task automatic send_v4(input logic [31:0] a);
    send_address(FAM_V4, {$urandom(), $urandom()}, {$urandom(), a});
  endtask

  task automatic test_v4_directed();
    // upper bits all set must not matter
    send_address(FAM_V4, '1, {32'hffff_ffff, 32'h0000_0000});
    send_v4(32'h0601_0203);
    send_v4(32'h0a00_0001);
    send_v4(32'h6440_0000);
    send_v4(32'h6480_0001);   // 100/8 outside the shared /10
    send_v4(32'h7f00_0001);
    send_v4(32'ha9fe_0101);
    send_v4(32'ha9fd_0000);   // 169/8 outside the link-local /16
    send_v4(32'hac10_0000);
    send_v4(32'hac20_0000);   // 172/8 outside the private /12
    send_v4(32'hc0a8_0101);
    send_v4(32'hc0a9_0000);   // 192/8 outside the private /16
    send_v4(32'he000_0001);
    send_v4(32'hf000_0000);
    send_v4(32'hffff_ffff);
  endtask

  task automatic test_v6_directed();
    send_address(FAM_V6, 64'hff02_0000_0000_0000, 64'h1);
    send_address(FAM_V6, 64'hfe80_0000_0000_0000, 64'h1);
    send_address(FAM_V6, 64'hfebf_0000_0000_0000, 64'h1);   // free low bits of byte 1
    send_address(FAM_V6, 64'hfe80_0000_0000_0000, 64'h2);
    send_address(FAM_V6, 64'hfd00_0000_0000_0000, 64'h0);
    send_address(FAM_V6, 64'h0, 64'h1);
    send_address(FAM_V6, 64'h0, 64'h0);
    send_address(FAM_V6, '1, '1);
  endtask

  task automatic test_unknown_family();
    send_address(FAM_OTHER, '1, '1);
    send_address(FAM_RSVD, '1, '1);
  endtask

  function automatic logic [31:0] random_v4();
    logic [31:0] a;
    logic        hit;
    a   = $urandom();
    hit = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: if (hit) a = (a & ~V4_MASK10) | V4_SHARED;  else a[31:24] = 8'h64;
      1: if (hit) a = (a & ~V4_MASK16) | V4_LINKLOC; else a[31:24] = 8'ha9;
      2: if (hit) a = (a & ~V4_MASK12) | V4_PRIV172; else a[31:24] = 8'hac;
      3: if (hit) a = (a & ~V4_MASK16) | V4_PRIV192; else a[31:24] = 8'hc0;
      4: a[31:24] = V4_TABLE_OCTETS[$urandom_range(16)];
      5: a[31:28] = V4_NIB_MCAST;
      6: a[31:28] = V4_NIB_RSVD;
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [127:0] random_v6();
    logic [127:0] v;
    v = {$urandom(), $urandom(), $urandom(), $urandom()};
    case ($urandom_range(9))
      0: v[127:120] = V6_MCAST_B0;
      1: v[127:118] = {V6_LINKLOC_B0, V6_LINKLOC_B1};
      2: begin
        // link-local loopback shape, byte 15 often one
        v[127:118] = {V6_LINKLOC_B0, V6_LINKLOC_B1};
        v[111:8]   = '0;
        if ($urandom_range(1)) v[7:0] = 8'h01;
      end
      3: v[127:121] = V6_ULA_B0;
      4: v[127:124] = 4'hf;
      5: v = 128'($urandom_range(2));
      6: begin
        // one bit away from ::1 or fe80::1
        v = $urandom_range(1) ? {V6_LINKLOC_B0, 8'h80, 112'h1} : 128'h1;
        v[$urandom_range(127)] ^= 1'b1;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_random_mix(input int count);
    logic [127:0] v6;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: send_address($urandom_range(1) ? FAM_OTHER : FAM_RSVD,
                        {$urandom(), $urandom()}, {$urandom(), $urandom()});
        1, 2, 3, 4: send_v4(random_v4());
        default: begin
          v6 = random_v6();
          send_address(FAM_V6, v6[127:64], v6[63:0]);
        end
      endcase
    end
  endtask

  initial begin
    rst               <= 1'b1;
    addr_ch.valid     <= 1'b0;
    addr_ch.family    <= FAM_OTHER;
    addr_ch.addr_high <= '0;
    addr_ch.addr_low  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 37;
    rx_idle_pct = 67;
    test_v4_directed();
    test_v6_directed();
    test_unknown_family();
    test_random_mix(235);

    tx_idle_pct = 67;
    rx_idle_pct = 37;
    test_random_mix(235);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mix(235);
    addr_ch.valid <= 1'b0;

    // drain; the watchdog bounds this wait
    while (expected_scopes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ipasc_pkg.sv
hw/rtl/ipasc_in_if.sv
hw/rtl/ipasc_out_if.sv
hw/rtl/ipasc_classify.sv
hw/rtl/ip_address_scope_classifier.sv
dv/ip_address_scope_classifier_tb.sv
